[rtl/gduk_pkg.sv]
`timescale 1ns / 1ps
// Shared types, field widths and divide-by-1000 helpers for the UTC keeper.
// Used by every module of the block; depends on nothing.
package gduk_pkg;

    localparam int EPOCH_W    = 40;
    localparam int MS_W       = 32;
    localparam int AGE_W      = 16;
    localparam int THR_W      = 8;
    localparam int QUO_W      = 23;
    localparam int FQUO_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 120;

    localparam int          RECIP_MS_W   = 29;
    localparam int          RECIP_MS_SH  = 38;
    localparam logic [RECIP_MS_W-1:0] RECIP_MS = 29'd274877907;
    localparam int          RECIP_AGE_W  = 17;
    localparam int          RECIP_AGE_SH = 26;
    localparam logic [RECIP_AGE_W-1:0] RECIP_AGE = 17'd67109;

    localparam logic [THR_W-1:0]      DRIFT_RST    = 8'd2;
    localparam logic [MS_W-1:0]       RESYNC_RST   = 32'd3600000;
    localparam logic [MS_W-1:0]       REANCHOR_RST = 32'd3600000;
    localparam logic [AGE_W-1:0]      MAX_AGE_RST  = 16'd1500;
    localparam logic [AGE_W-1:0]      TASK_RST     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIFT    = 3'd0,
        CFG_RESYNC   = 3'd1,
        CFG_REANCHOR = 3'd2,
        CFG_MAX_AGE  = 3'd3,
        CFG_TASK     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RTC  = 2'd1,
        SRC_GNSS = 2'd2
    } src_t;

    typedef enum logic {
        OP_RTC_LOAD = 1'b0,
        OP_TICK     = 1'b1
    } op_t;

    typedef struct packed {
        logic [THR_W-1:0] drift_thr;
        logic [MS_W-1:0]  resync_ms;
        logic [MS_W-1:0]  span_ms;
        logic [AGE_W-1:0] max_age;
        logic [AGE_W-1:0] task_ms;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [MS_W-1:0]    now_ms;
        logic               rtc_ok;
        logic [EPOCH_W-1:0] rtc_epoch;
        logic               fix_ok;
        logic [EPOCH_W-1:0] fix_epoch;
        logic [AGE_W-1:0]   fix_age;
        logic               sync_req;
    } item_t;

    typedef struct packed {
        logic [MS_W-1:0]    now_ms;
        logic               seeded;
        src_t               src;
        logic [EPOCH_W-1:0] anchor_sec;
        logic [MS_W-1:0]    anchor_ms;
        logic               synced;
        logic [MS_W-1:0]    last_sync_ms;
        logic               wr;
        logic [EPOCH_W-1:0] wr_value;
    } snap_t;

    // Exact x / 1000 for any 32-bit x by a reciprocal multiply.
    function automatic logic [QUO_W-1:0] div_ms(input logic [MS_W-1:0] x);
        logic [MS_W+RECIP_MS_W-1:0] prod;
        prod = x * RECIP_MS;
        return prod[MS_W+RECIP_MS_W-1:RECIP_MS_SH];
    endfunction

    // Exact x / 1000 for any 16-bit x.
    function automatic logic [FQUO_W-1:0] div_age(input logic [AGE_W-1:0] x);
        logic [AGE_W+RECIP_AGE_W-1:0] prod;
        prod = x * RECIP_AGE;
        return prod[AGE_W+RECIP_AGE_W-1:RECIP_AGE_SH];
    endfunction

    // q * 1000 as shifts and subtracts.
    function automatic logic [MS_W-1:0] times_1000(input logic [QUO_W-1:0] q);
        logic [MS_W-1:0] w;
        w = {{(MS_W-QUO_W){1'b0}}, q};
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

[rtl/gnss_disciplined_utc_keeper_unit.sv]
`timescale 1ns / 1ps
// Top level of the GNSS-disciplined UTC keeper: ports, configuration and pipeline.
// Depends on gduk_pkg and gduk_state.
//
// Each word on the s_ channel is an RTC load (s_tuser low) or a housekeeping
// tick (s_tuser high) stamped with the free-running millisecond count. Every
// word yields exactly one word on the m_ channel with the current UTC second,
// the time source, an optional RTC write order and the age of the last sync.
// Configuration registers are written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high and indexes beyond the list are ignored.
// The pipeline has three register stages: input, clock state update, result.
// Each word moves from the input register to the middle and then the result register.
// One word is taken every cycle unless m_tready stalls; the clock state loop closes
// through a reciprocal multiplier that divides the elapsed count by 1000.
// Reset clears the clock state, the pipeline and restores register defaults.
// When m_tready is low the result holds and the input and middle stages keep
// filling, so up to three words are held before s_tready drops.
module gnss_disciplined_utc_keeper_unit import gduk_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], rtc_ok[32], rtc_epoch[72:33], fix_ok[73], fix_epoch[113:74],
    // fix_age_ms[129:114], sync_request[130], zero padding[135:131]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // now_utc[39:0], time_valid[40], time_source[42:41], rtc_write[43],
    // rtc_write_value[83:44], sync_age_s[115:84], zero padding[119:116]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    item_t in_item;
    item_t in_item_reg;
    logic  in_valid_reg, in_valid_next;
    snap_t snap;
    snap_t mid_reg;
    logic  mid_valid_reg, mid_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic  adv_mid, adv_out, s_fire;

    logic [EPOCH_W-1:0] res_utc;
    logic [MS_W-1:0]    res_age;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drift_thr <= DRIFT_RST;
            cfg_reg.resync_ms <= RESYNC_RST;
            cfg_reg.span_ms   <= REANCHOR_RST;
            cfg_reg.max_age   <= MAX_AGE_RST;
            cfg_reg.task_ms   <= TASK_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DRIFT:    cfg_reg.drift_thr <= cfg_data[THR_W-1:0];
                CFG_RESYNC:   cfg_reg.resync_ms <= cfg_data[MS_W-1:0];
                CFG_REANCHOR: cfg_reg.span_ms   <= cfg_data[MS_W-1:0];
                CFG_MAX_AGE:  cfg_reg.max_age   <= cfg_data[AGE_W-1:0];
                CFG_TASK:     cfg_reg.task_ms   <= cfg_data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item.op        = op_t'(s_tuser[0]);
        in_item.now_ms    = s_tdata[31:0];
        in_item.rtc_ok    = s_tdata[32];
        in_item.rtc_epoch = s_tdata[72:33];
        in_item.fix_ok    = s_tdata[73];
        in_item.fix_epoch = s_tdata[113:74];
        in_item.fix_age   = s_tdata[129:114];
        in_item.sync_req  = s_tdata[130];
    end

    assign adv_out  = out_valid_reg ? m_tready : 1'b1;
    assign adv_mid  = in_valid_reg && (!mid_valid_reg || adv_out);
    assign s_tready = !in_valid_reg || adv_mid;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (adv_mid ? 1'b0 : in_valid_reg);
        mid_valid_next = adv_mid ? 1'b1 : ((mid_valid_reg && adv_out) ? 1'b0 : mid_valid_reg);
        out_valid_next = (mid_valid_reg && adv_out) ? 1'b1
                         : (m_tready ? 1'b0 : out_valid_reg);
    end

    gduk_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .adv     (adv_mid),
        .item    (in_item_reg),
        .snap    (snap)
    );

    always_comb begin
        res_utc = mid_reg.seeded
                  ? mid_reg.anchor_sec + EPOCH_W'(div_ms(mid_reg.now_ms - mid_reg.anchor_ms))
                  : '0;
        res_age = mid_reg.synced
                  ? MS_W'(div_ms(mid_reg.now_ms - mid_reg.last_sync_ms))
                  : '1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item;
        end
        if (adv_mid) begin
            mid_reg <= snap;
        end
        if (mid_valid_reg && adv_out) begin
            out_data_reg <= {4'b0, res_age, mid_reg.wr_value, mid_reg.wr,
                             mid_reg.src, mid_reg.seeded, res_utc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/gduk_state.sv]
`timescale 1ns / 1ps
// Clock state of the UTC keeper and its update for each word.
// Depends on gduk_pkg.
module gduk_state import gduk_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  adv,
    input  item_t item,
    output snap_t snap
);

    logic [EPOCH_W-1:0] anchor_sec_reg, anchor_sec_next;
    logic [MS_W-1:0]    anchor_ms_reg, anchor_ms_next;
    logic               seeded_reg, seeded_next;
    src_t               src_reg, src_next;
    logic               synced_reg, synced_next;
    logic [MS_W-1:0]    last_sync_reg, last_sync_next;
    logic               pending_reg, pending_next;
    logic [MS_W-1:0]    last_task_reg, last_task_next;

    logic [MS_W-1:0]    elapsed;
    logic [QUO_W-1:0]   whole;
    logic [EPOCH_W-1:0] utc_now;
    logic [EPOCH_W-1:0] gnss_now;
    logic               task_due;
    logic               slide;
    logic               fix_fresh;
    logic               pending_now;
    logic [MS_W-1:0]    drift;
    logic signed [MS_W:0] drift_s;
    logic signed [MS_W:0] thr_s;
    logic               drift_big;
    logic               due;
    logic               wr;

    always_comb begin
        elapsed     = item.now_ms - anchor_ms_reg;
        whole       = div_ms(elapsed);
        utc_now     = seeded_reg ? anchor_sec_reg + EPOCH_W'(whole) : '0;
        gnss_now    = item.fix_epoch + EPOCH_W'(div_age(item.fix_age));
        task_due    = (item.now_ms - last_task_reg) >= MS_W'(cfg.task_ms);
        slide       = seeded_reg && (elapsed > cfg.span_ms);
        fix_fresh   = item.fix_ok && (item.fix_age < cfg.max_age);
        pending_now = pending_reg | item.sync_req;
        drift       = gnss_now[MS_W-1:0] - utc_now[MS_W-1:0];
        drift_s     = {drift[MS_W-1], drift};
        thr_s       = {{(MS_W+1-THR_W){1'b0}}, cfg.drift_thr};
        drift_big   = (drift_s >= thr_s) || (drift_s <= -thr_s);
        due         = !synced_reg || pending_now || drift_big
                      || ((item.now_ms - last_sync_reg) > cfg.resync_ms);

        anchor_sec_next = anchor_sec_reg;
        anchor_ms_next  = anchor_ms_reg;
        seeded_next     = seeded_reg;
        src_next        = src_reg;
        synced_next     = synced_reg;
        last_sync_next  = last_sync_reg;
        pending_next    = pending_reg;
        last_task_next  = last_task_reg;
        wr              = 1'b0;

        if (item.op == OP_RTC_LOAD) begin
            if (item.rtc_ok) begin
                anchor_sec_next = item.rtc_epoch;
                anchor_ms_next  = item.now_ms;
                seeded_next     = 1'b1;
                src_next        = SRC_RTC;
            end
        end else begin
            pending_next = pending_now;
            if (task_due) begin
                last_task_next = item.now_ms;
                if (slide) begin
                    anchor_sec_next = anchor_sec_reg + EPOCH_W'(whole);
                    anchor_ms_next  = anchor_ms_reg + times_1000(whole);
                end
                if (fix_fresh && due) begin
                    anchor_sec_next = item.fix_epoch;
                    anchor_ms_next  = item.now_ms - MS_W'(item.fix_age);
                    seeded_next     = 1'b1;
                    src_next        = SRC_GNSS;
                    synced_next     = 1'b1;
                    last_sync_next  = item.now_ms;
                    pending_next    = 1'b0;
                    wr              = 1'b1;
                end
            end
        end

        snap.now_ms       = item.now_ms;
        snap.seeded       = seeded_next;
        snap.src          = src_next;
        snap.anchor_sec   = anchor_sec_next;
        snap.anchor_ms    = anchor_ms_next;
        snap.synced       = synced_next;
        snap.last_sync_ms = last_sync_next;
        snap.wr           = wr;
        snap.wr_value     = wr ? gnss_now : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_sec_reg <= '0;
            anchor_ms_reg  <= '0;
            seeded_reg     <= 1'b0;
            src_reg        <= SRC_NONE;
            synced_reg     <= 1'b0;
            last_sync_reg  <= '0;
            pending_reg    <= 1'b0;
            last_task_reg  <= '0;
        end else if (adv) begin
            anchor_sec_reg <= anchor_sec_next;
            anchor_ms_reg  <= anchor_ms_next;
            seeded_reg     <= seeded_next;
            src_reg        <= src_next;
            synced_reg     <= synced_next;
            last_sync_reg  <= last_sync_next;
            pending_reg    <= pending_next;
            last_task_reg  <= last_task_next;
        end
    end

endmodule

[rtl/gduk_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result stream of the UTC keeper, bound to the top level.
// Depends on gduk_pkg and gnss_disciplined_utc_keeper_unit.
module gduk_checker import gduk_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [EPOCH_W-1:0] utc;
    logic               tvld;
    logic [1:0]         src;
    logic               wr;
    logic [EPOCH_W-1:0] wval;
    logic [MS_W-1:0]    age;

    assign utc  = m_tdata[39:0];
    assign tvld = m_tdata[40];
    assign src  = m_tdata[42:41];
    assign wr   = m_tdata[43];
    assign wval = m_tdata[83:44];
    assign age  = m_tdata[115:84];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (tvld == (src != SRC_NONE)))
        else $error("time valid flag disagrees with time source");

    a_unseeded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !tvld |-> (utc == '0))
        else $error("unseeded clock reports nonzero time");

    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && wr |-> (src == SRC_GNSS) && (age == '0) && (utc == wval))
        else $error("RTC write without a fresh GNSS sync");

    a_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !wr |-> (wval == '0))
        else $error("RTC write value present without a write");

endmodule

bind gnss_disciplined_utc_keeper_unit gduk_checker u_gduk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gnss_disciplined_utc_keeper_unit: a directed script, then
// random RTC loads and GNSS ticks under several register settings, all checked word by word.
// Depends on gduk_pkg and the RTL of the block; reads and writes no files.
module testbench;
    import gduk_pkg::*;

    localparam int          DIRECTED_ROWS = 20;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          PHASE_WORDS   = 190;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;

    typedef struct packed {
        logic [EPOCH_W-1:0] utc;
        logic               valid;
        src_t               src;
        logic               wr;
        logic [EPOCH_W-1:0] wr_value;
        logic [MS_W-1:0]    age_s;
    } keeper_out_t;

    typedef struct packed {
        item_t       word;
        logic        checked;
        keeper_out_t want;
    } script_row_t;

    localparam keeper_out_t UNSEEDED = '{40'd0, 1'b0, SRC_NONE, 1'b0, 40'd0, 32'hFFFFFFFF};
    localparam keeper_out_t NO_CHECK = '0;

    // Rows with a typed result can be read straight off the behavior; the rest use the
    // predictor. Times follow the reset register values.
    localparam script_row_t SCRIPT [0:DIRECTED_ROWS-1] = '{
        '{'{OP_TICK, 32'd0, 1'b0, 40'd0, 1'b1, 40'd1000, 16'd0, 1'b0}, 1'b1, UNSEEDED},
        '{'{OP_RTC_LOAD, 32'd5, 1'b0, 40'd12345, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b1, UNSEEDED},
        '{'{OP_TICK, 32'd999, 1'b0, 40'd0, 1'b0, 40'd0, 16'd0, 1'b1}, 1'b1, UNSEEDED},
        '{'{OP_RTC_LOAD, 32'd1000, 1'b1, 40'hFFFFFFFFFF, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b1,
          '{40'hFFFFFFFFFF, 1'b1, SRC_RTC, 1'b0, 40'd0, 32'hFFFFFFFF}},
        '{'{OP_TICK, 32'd3500, 1'b0, 40'd0, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b1,
          '{40'd1, 1'b1, SRC_RTC, 1'b0, 40'd0, 32'hFFFFFFFF}},
        '{'{OP_RTC_LOAD, 32'd4000, 1'b1, 40'd1000000, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b1,
          '{40'd1000000, 1'b1, SRC_RTC, 1'b0, 40'd0, 32'hFFFFFFFF}},
        '{'{OP_TICK, 32'd4999, 1'b0, 40'd0, 1'b1, 40'd1000000, 16'd1500, 1'b0}, 1'b1,
          '{40'd1000000, 1'b1, SRC_RTC, 1'b0, 40'd0, 32'hFFFFFFFF}},
        '{'{OP_TICK, 32'd6000, 1'b0, 40'd0, 1'b1, 40'd1000001, 16'd900, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd7000, 1'b0, 40'd0, 1'b1, 40'd1000002, 16'd0, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd8000, 1'b0, 40'd0, 1'b1, 40'd1000005, 16'd10, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd9000, 1'b0, 40'd0, 1'b1, 40'd999000, 16'd0, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd9500, 1'b0, 40'd0, 1'b1, 40'd999001, 16'd0, 1'b1}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd10000, 1'b0, 40'd0, 1'b1, 40'd999001, 16'd0, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'd3610001, 1'b0, 40'd0, 1'b1, 40'd1002601, 16'd0, 1'b0}, 1'b0,
          NO_CHECK},
        '{'{OP_TICK, 32'hFFFFFFFF, 1'b0, 40'd0, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, 32'h00000FA0, 1'b0, 40'd0, 1'b1, 40'hFFFFFFFFFF, 16'd1499, 1'b0}, 1'b0,
          NO_CHECK},
        '{'{OP_RTC_LOAD, 32'd5000, 1'b1, 40'd0, 1'b0, 40'd0, 16'd0, 1'b0}, 1'b0, NO_CHECK},
        '{'{OP_TICK, '1, 1'b1, '1, 1'b1, '1, '1, 1'b1}, 1'b0, NO_CHECK},
        '{'{OP_RTC_LOAD, '1, 1'b1, '1, 1'b1, '1, '1, 1'b1}, 1'b0, NO_CHECK},
        '{'{OP_RTC_LOAD, 32'd77, 1'b0, '1, 1'b1, '1, '1, 1'b1}, 1'b0, NO_CHECK}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state and its copy of the registers.
    logic [EPOCH_W-1:0] kp_anchor_sec     = '0;
    logic [MS_W-1:0]    kp_anchor_ms      = '0;
    logic               kp_seeded         = 1'b0;
    src_t               kp_source         = SRC_NONE;
    logic               kp_synced         = 1'b0;
    logic [MS_W-1:0]    kp_last_sync_ms   = '0;
    logic               kp_resync_pending = 1'b0;
    logic [MS_W-1:0]    kp_last_pass_ms   = '0;
    logic [THR_W-1:0]   set_drift         = DRIFT_RST;
    logic [MS_W-1:0]    set_resync        = RESYNC_RST;
    logic [MS_W-1:0]    set_reanchor      = REANCHOR_RST;
    logic [AGE_W-1:0]   set_max_age       = MAX_AGE_RST;
    logic [AGE_W-1:0]   set_period        = TASK_RST;

    keeper_out_t        utc_reports_q[$];
    int unsigned        mismatch_count  = 0;
    int unsigned        words_sent      = 0;
    int unsigned        reports_checked = 0;
    int unsigned        writes_seen     = 0;
    int unsigned        settings_used   = 0;
    int unsigned        cycle_count     = 0;
    int unsigned        burst_left      = 0;
    int unsigned        rx_tick         = 0;
    int unsigned        rx_mode         = 0;
    logic [MS_W-1:0]    ms_counter      = '0;
    logic [EPOCH_W-1:0] sky_sec         = '0;
    logic [MS_W-1:0]    sky_ms          = '0;

    gnss_disciplined_utc_keeper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [EPOCH_W-1:0] rand40();
        return {8'($urandom), $urandom};
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(input item_t w);
        return {5'd0, w.sync_req, w.fix_age, w.fix_epoch, w.fix_ok, w.rtc_epoch, w.rtc_ok,
                w.now_ms};
    endfunction

    function automatic logic [EPOCH_W-1:0] utc_reading(input logic [MS_W-1:0] now);
        logic [MS_W-1:0] el;
        el = now - kp_anchor_ms;
        if (!kp_seeded) begin
            return '0;
        end
        return kp_anchor_sec + 40'(el / 1000);
    endfunction

    function automatic keeper_out_t advance_keeper(input item_t w);
        keeper_out_t        r;
        logic [MS_W-1:0]    el;
        logic [MS_W-1:0]    whole;
        logic [EPOCH_W-1:0] gnss_now;
        logic [EPOCH_W-1:0] d40;
        logic signed [31:0] drift_s;
        logic               due;
        r = '0;
        if (w.op == OP_RTC_LOAD) begin
            if (w.rtc_ok) begin
                kp_anchor_sec = w.rtc_epoch;
                kp_anchor_ms  = w.now_ms;
                kp_seeded     = 1'b1;
                kp_source     = SRC_RTC;
            end
        end else begin
            if (w.sync_req) begin
                kp_resync_pending = 1'b1;
            end
            el = w.now_ms - kp_last_pass_ms;
            if (el >= 32'(set_period)) begin
                kp_last_pass_ms = w.now_ms;
                el = w.now_ms - kp_anchor_ms;
                if (kp_seeded && el > set_reanchor) begin
                    whole = el / 1000;
                    kp_anchor_sec = kp_anchor_sec + 40'(whole);
                    kp_anchor_ms = kp_anchor_ms + whole * 1000;
                end
                if (w.fix_ok && w.fix_age < set_max_age) begin
                    gnss_now = w.fix_epoch + 40'(w.fix_age / 1000);
                    due = !kp_synced || kp_resync_pending;
                    if (!due) begin
                        d40 = gnss_now - utc_reading(w.now_ms);
                        drift_s = $signed(d40[31:0]);
                        if (longint'(drift_s) >= longint'(set_drift) ||
                            longint'(drift_s) <= -longint'(set_drift)) begin
                            due = 1'b1;
                        end else if (w.now_ms - kp_last_sync_ms > set_resync) begin
                            due = 1'b1;
                        end
                    end
                    if (due) begin
                        kp_anchor_sec     = w.fix_epoch;
                        kp_anchor_ms      = w.now_ms - 32'(w.fix_age);
                        kp_seeded         = 1'b1;
                        kp_source         = SRC_GNSS;
                        kp_synced         = 1'b1;
                        kp_last_sync_ms   = w.now_ms;
                        kp_resync_pending = 1'b0;
                        r.wr              = 1'b1;
                        r.wr_value        = gnss_now;
                    end
                end
            end
        end
        r.utc   = utc_reading(w.now_ms);
        r.valid = kp_seeded;
        r.src   = kp_source;
        el      = w.now_ms - kp_last_sync_ms;
        r.age_s = kp_synced ? el / 1000 : 32'hFFFFFFFF;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < 40) begin
            $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_word(input item_t w, input logic checked, input keeper_out_t want);
        keeper_out_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= pack_word(w);
        s_tuser  <= w.op;
        do @(posedge aclk); while (!s_tready);
        predicted = advance_keeper(w);
        utc_reports_q.push_back(checked ? want : predicted);
        words_sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DRIFT:    set_drift    = val[THR_W-1:0];
            CFG_RESYNC:   set_resync   = val;
            CFG_REANCHOR: set_reanchor = val;
            CFG_MAX_AGE:  set_max_age  = val[AGE_W-1:0];
            CFG_TASK:     set_period   = val[AGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] thr, input logic [31:0] resync,
                                  input logic [31:0] reanchor, input logic [31:0] max_age,
                                  input logic [31:0] period);
        s_tvalid <= 1'b0;
        while (utc_reports_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(CFG_DRIFT, thr);
        write_reg(CFG_RESYNC, resync);
        write_reg(CFG_REANCHOR, reanchor);
        write_reg(CFG_MAX_AGE, max_age);
        write_reg(CFG_TASK, period);
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly a steady millisecond count with a GNSS view of true time that drifts now
    // and then; the rest is RTC loads and words with every field random.
    task automatic run_phase(input int unsigned n_words, input logic [EPOCH_W-1:0] start_sec,
                             input logic [MS_W-1:0] start_ms);
        item_t              w;
        logic [MS_W-1:0]    dt;
        logic [MS_W-1:0]    el;
        logic [MS_W-1:0]    whole;
        logic [EPOCH_W-1:0] skew;
        int unsigned        pick;
        int unsigned        age_cap;
        ms_counter = start_ms;
        sky_ms     = start_ms;
        sky_sec    = start_sec;
        skew       = '0;
        for (int unsigned i = 0; i < n_words; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                dt = $urandom_range(0, 2 * int'(set_period) + 50);
            end else if (pick < 80) begin
                dt = set_reanchor + $urandom_range(0, 3000);
            end else if (pick < 92) begin
                dt = set_resync + $urandom_range(0, 3000);
            end else begin
                dt = $urandom;
            end
            ms_counter = ms_counter + dt;
            el = ms_counter - sky_ms;
            whole = el / 1000;
            sky_sec = sky_sec + 40'(whole);
            sky_ms = sky_ms + whole * 1000;

            w.now_ms    = ms_counter;
            w.rtc_ok    = 1'($urandom_range(0, 1));
            w.rtc_epoch = rand40();
            w.fix_ok    = 1'($urandom_range(0, 1));
            w.fix_epoch = rand40();
            w.fix_age   = 16'($urandom);
            w.sync_req  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                w.op     = op_t'($urandom_range(0, 1));
                w.now_ms = $urandom;
            end else if (pick < 22) begin
                w.op        = OP_RTC_LOAD;
                w.rtc_ok    = ($urandom_range(0, 7) != 0);
                w.rtc_epoch = sky_sec + 40'($urandom_range(0, 6)) - 40'd3;
            end else begin
                w.op     = OP_TICK;
                w.fix_ok = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) < 8 && set_max_age != 0) begin
                    age_cap = (set_max_age > 16'd2000) ? 1999 : int'(set_max_age) - 1;
                    w.fix_age = 16'($urandom_range(0, age_cap));
                end
                if ($urandom_range(0, 6) == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        skew = rand40();
                    end else begin
                        skew = 40'($urandom_range(0, 2 * int'(set_drift) + 4))
                             - 40'(set_drift) - 40'd2;
                    end
                end
                w.fix_epoch = sky_sec + skew - 40'(w.fix_age / 1000);
                w.sync_req  = ($urandom_range(0, 11) == 0);
            end
            send_word(w, 1'b0, NO_CHECK);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words sent.", cycle_count, words_sent);
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        keeper_out_t got;
        keeper_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.utc      = m_tdata[39:0];
            got.valid    = m_tdata[40];
            got.src      = src_t'(m_tdata[42:41]);
            got.wr       = m_tdata[43];
            got.wr_value = m_tdata[83:44];
            got.age_s    = m_tdata[115:84];
            if (got.wr) begin
                writes_seen++;
            end
            if (utc_reports_q.size() == 0) begin
                note_mismatch("word with nothing expected", 64'(m_tdata[63:0]), 64'd0);
            end else begin
                want = utc_reports_q.pop_front();
                reports_checked++;
                if (got.utc !== want.utc)
                    note_mismatch("now_utc", 64'(got.utc), 64'(want.utc));
                if (got.valid !== want.valid)
                    note_mismatch("time_valid", 64'(got.valid), 64'(want.valid));
                if (got.src !== want.src)
                    note_mismatch("time_source", 64'(got.src), 64'(want.src));
                if (got.wr !== want.wr)
                    note_mismatch("rtc_write", 64'(got.wr), 64'(want.wr));
                if (got.wr_value !== want.wr_value)
                    note_mismatch("rtc_write_value", 64'(got.wr_value), 64'(want.wr_value));
                if (got.age_s !== want.age_s)
                    note_mismatch("sync_age_s", 64'(got.age_s), 64'(want.age_s));
                if (m_tdata[119:116] !== 4'd0)
                    note_mismatch("padding", 64'(m_tdata[119:116]), 64'd0);
            end
        end
        rx_tick++;
        if (rx_tick % 256 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_tick % 7) < 3;
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_word(SCRIPT[r].word, SCRIPT[r].checked, SCRIPT[r].want);
        end

        apply_settings(32'd3, 32'd20000, 32'd5000, 32'd1200, 32'd200);
        run_phase(PHASE_WORDS, rand40(), 32'd20000);
        apply_settings(32'd0, 32'd1, 32'd1000, 32'd1, 32'd0);
        run_phase(PHASE_WORDS, rand40(), $urandom);
        apply_settings(32'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd65535, 32'd65535);
        run_phase(PHASE_WORDS, 40'hFFFFFFFF00, 32'hFFF00000);
        apply_settings({24'($urandom), 8'($urandom_range(1, 6))}, $urandom_range(1000, 60000),
                       $urandom_range(0, 999), {16'($urandom), 16'd0},
                       {16'($urandom), 16'($urandom_range(0, 300))});
        run_phase(PHASE_WORDS, rand40(), $urandom);
        apply_settings($urandom_range(1, 255), $urandom_range(1000, 100000),
                       $urandom_range(1000, 50000), $urandom_range(1, 3000),
                       $urandom_range(0, 2000));
        run_phase(PHASE_WORDS, rand40(), $urandom);
        apply_settings(32'(DRIFT_RST), RESYNC_RST, REANCHOR_RST, 32'(MAX_AGE_RST),
                       32'(TASK_RST));
        run_phase(PHASE_WORDS, rand40(), $urandom);

        s_tvalid <= 1'b0;
        while (utc_reports_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (utc_reports_q.size() != 0) begin
            note_mismatch("results never delivered", 64'(utc_reports_q.size()), 64'd0);
        end

        $display("Sent %0d words under %0d register settings after the reset defaults.",
                 words_sent, settings_used);
        $display("Checked %0d results, %0d of them RTC write orders; %0d mismatches.",
                 reports_checked, writes_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gduk_pkg.sv
rtl/gduk_state.sv
rtl/gnss_disciplined_utc_keeper_unit.sv
rtl/gduk_checker.sv
dv/testbench.sv
